>>> sv/wgm_pkg.sv
// Shared types and codes for the wildcard glob matcher.
// No dependencies; every other file imports this package.
package wgm_pkg;

    // Width of the character port on the item channel.
    localparam int CH_IN_W = 16;

    typedef logic [1:0] t_func;

    localparam t_func FUNC_CLEAR  = 2'd0;
    localparam t_func FUNC_APPEND = 2'd1;
    localparam t_func FUNC_TEXT   = 2'd2;
    localparam t_func FUNC_QUERY  = 2'd3;

    localparam logic [7:0] STAR_CH  = 8'h2A;
    localparam logic [7:0] QMARK_CH = 8'h3F;

    // Pattern store command for one transaction.
    typedef struct packed {
        logic clr;
        logic app;
    } t_pat_cmd;

endpackage

>>> sv/wildcard_glob_matcher_core.sv
// Top level of the wildcard glob matcher: input register, position set, result register.
// Instantiates wgm_pattern_store and wgm_pos_update; depends on wgm_pkg.
//
//  channel | direction | valid   | stall   | payload
//  --------+-----------+---------+---------+---------------------------------
//  item    | in        | i_valid | o_stall | i_func, i_ch, i_last
//  result  | out       | o_valid | i_stall | o_matched, o_pattern_overflow
//
// One transaction per cycle unless stalled; a result is registered when its item advances.
// The input register and the result register sit around the
// position-set update, a ripple over MAX_PATTERN star positions.
// Reset (i_rst_n low, synchronous) empties the pattern, clears the overflow
// flag and restarts the position set; the pattern characters are not cleared.
// A stalled result holds the item register only when that item makes a result.
module wildcard_glob_matcher_core
    import wgm_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    parameter int CHAR_WIDTH  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic [CH_IN_W-1:0] i_ch,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_matched,
    output logic               o_pattern_overflow
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam logic [MAX_PATTERN:0] POS_START = {{MAX_PATTERN{1'b0}}, 1'b1};

    logic               r_in_vld;
    logic               n_in_vld;
    t_func              r_func;
    logic [CH_IN_W-1:0] r_ch;
    logic               r_last;

    logic [MAX_PATTERN:0] r_pos;
    logic [MAX_PATTERN:0] n_pos;

    logic r_out_vld;
    logic n_out_vld;
    logic r_matched;
    logic n_matched;
    logic r_ovf_out;
    logic n_ovf_out;

    logic                   produces;
    logic                   adv;
    logic                   in_acc;
    t_pat_cmd               pat_cmd;
    logic [MAX_PATTERN-1:0] star;
    logic [MAX_PATTERN-1:0] step;
    logic [CNT_W-1:0]       cnt;
    logic                   ovf;
    logic [MAX_PATTERN:0]   pos_next;
    logic                   text_hit;
    logic                   query_hit;

    assign produces = ((r_func == FUNC_TEXT) && r_last) || (r_func == FUNC_QUERY);
    assign adv      = r_in_vld && (!produces || !r_out_vld || !i_stall);
    assign o_stall  = r_in_vld && !adv;
    assign in_acc   = i_valid && !o_stall;

    assign pat_cmd.clr = adv && (r_func == FUNC_CLEAR);
    assign pat_cmd.app = adv && (r_func == FUNC_APPEND);

    wgm_pattern_store #(
        .MAX_PATTERN(MAX_PATTERN),
        .CHAR_WIDTH (CHAR_WIDTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (pat_cmd),
        .i_ch   (CHAR_WIDTH'(r_ch)),
        .o_star (star),
        .o_step (step),
        .o_cnt  (cnt),
        .o_ovf  (ovf)
    );

    wgm_pos_update #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_pos (
        .i_pos      (r_pos),
        .i_star     (star),
        .i_step     (step),
        .i_cnt      (cnt),
        .o_next     (pos_next),
        .o_text_hit (text_hit),
        .o_query_hit(query_hit)
    );

    always_comb begin
        n_in_vld  = r_in_vld;
        n_pos     = r_pos;
        n_out_vld = r_out_vld;
        n_matched = r_matched;
        n_ovf_out = r_ovf_out;

        if (in_acc) begin
            n_in_vld = 1'b1;
        end else if (adv) begin
            n_in_vld = 1'b0;
        end

        // Drop a delivered result.
        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end

        if (adv) begin
            case (r_func)
                FUNC_CLEAR: begin
                    n_pos = POS_START;
                end
                FUNC_TEXT: begin
                    n_pos = r_last ? POS_START : pos_next;
                end
                default: begin
                end
            endcase
            if (produces) begin
                n_out_vld = 1'b1;
                n_matched = ((r_func == FUNC_QUERY) ? query_hit : text_hit) && !ovf;
                n_ovf_out = ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_pos     <= POS_START;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            r_pos     <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func <= i_func;
            r_ch   <= i_ch;
            r_last <= i_last;
        end
        r_matched <= n_matched;
        r_ovf_out <= n_ovf_out;
    end

    assign o_valid            = r_out_vld;
    assign o_matched          = r_matched;
    assign o_pattern_overflow = r_ovf_out;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_vld)
        else $error("item side stalled with no held transaction");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && produces |=> o_valid)
        else $error("result transaction not registered");

    a_clear_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && (r_func == FUNC_CLEAR) |=> (r_pos == POS_START) && (cnt == '0) && !ovf)
        else $error("clear did not restart pattern and positions");

    a_ovf_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_matched && o_pattern_overflow))
        else $error("match reported with pattern overflow");

endmodule

>>> sv/wgm_pattern_store.sv
// Pattern character store with fill count and overflow flag.
// Produces per-position star and single-step masks. Depends on wgm_pkg.
module wgm_pattern_store
    import wgm_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    parameter int CHAR_WIDTH  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_pat_cmd                             i_cmd,
    input  logic [CHAR_WIDTH-1:0]                i_ch,
    output logic [MAX_PATTERN-1:0]               o_star,
    output logic [MAX_PATTERN-1:0]               o_step,
    output logic [$clog2(MAX_PATTERN+1)-1:0]     o_cnt,
    output logic                                 o_ovf
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam logic [CHAR_WIDTH-1:0] STAR_W  = CHAR_WIDTH'(STAR_CH);
    localparam logic [CHAR_WIDTH-1:0] QMARK_W = CHAR_WIDTH'(QMARK_CH);

    logic [CHAR_WIDTH-1:0] r_store [MAX_PATTERN];
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic                  r_ovf;
    logic                  n_ovf;
    logic                  full;

    assign full = (r_cnt == CNT_W'(MAX_PATTERN));

    always_comb begin
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (i_cmd.clr) begin
            n_cnt = '0;
            n_ovf = 1'b0;
        end else if (i_cmd.app) begin
            if (full) begin
                n_ovf = 1'b1;
            end else begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
    end

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_entry
        logic in_pat;
        logic is_star;

        always_ff @(posedge i_clk) begin
            if (i_cmd.app && !i_cmd.clr && (r_cnt == CNT_W'(g))) begin
                r_store[g] <= i_ch;
            end
        end

        // Only entries below the fill count take part.
        assign in_pat    = (CNT_W'(g) < r_cnt);
        assign is_star   = (r_store[g] == STAR_W);
        assign o_star[g] = in_pat && is_star;
        assign o_step[g] = in_pat && !is_star &&
                           ((r_store[g] == QMARK_W) || (r_store[g] == i_ch));
    end

    assign o_cnt = r_cnt;
    assign o_ovf = r_ovf;

endmodule

>>> sv/wgm_pos_update.sv
// Position set update: star closure and one-character advance.
// Pure combinational; depends on wgm_pkg for house conventions only.
module wgm_pos_update
    import wgm_pkg::*;
#(
    parameter int MAX_PATTERN = 32
) (
    input  logic [MAX_PATTERN:0]                 i_pos,
    input  logic [MAX_PATTERN-1:0]               i_star,
    input  logic [MAX_PATTERN-1:0]               i_step,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]     i_cnt,
    output logic [MAX_PATTERN:0]                 o_next,
    output logic                                 o_text_hit,
    output logic                                 o_query_hit
);

    localparam logic [MAX_PATTERN:0] POS_START = {{MAX_PATTERN{1'b0}}, 1'b1};

    // Ripple a reached position across each run of stars, like a carry chain.
    function automatic logic [MAX_PATTERN:0] f_close(input logic [MAX_PATTERN:0] s,
                                                     input logic [MAX_PATTERN-1:0] st);
        logic [MAX_PATTERN:0] r;
        r = s;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            r[i+1] = r[i+1] | (r[i] & st[i]);
        end
        return r;
    endfunction

    logic [MAX_PATTERN:0] cur;
    logic [MAX_PATTERN:0] nxt_closed;
    logic [MAX_PATTERN:0] query_closed;

    assign cur    = f_close(i_pos, i_star);
    // Stars hold their position, other matches advance one.
    assign o_next = {1'b0, cur[MAX_PATTERN-1:0] & i_star} |
                    {cur[MAX_PATTERN-1:0] & i_step, 1'b0};

    assign nxt_closed   = f_close(o_next, i_star);
    assign query_closed = f_close(POS_START, i_star);

    assign o_text_hit  = nxt_closed[i_cnt];
    assign o_query_hit = query_closed[i_cnt];

endmodule
